FILE: sv/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// shared constants, codes and types of the length-prefixed frame decoder
// ----------------------------------------------------------------------------
package lpfd_pkg;

   localparam int MAX_LEN_BYTES = 2;
   localparam int LEN_CNT_W     = $clog2(MAX_LEN_BYTES + 1);

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 14;
   localparam int LEN_GROUP_W = 7;
   localparam int STATUS_W    = 2;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h7E;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CSUM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LEN_ERR  = 2'd2;

   typedef struct packed {
      logic                valid;
      logic                kind;
      logic [BYTE_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    length;
   } result_type;

endpackage

FILE: sv/lpfd_if.sv
// ----------------------------------------------------------------------------
// lpfd_if
// valid/ready channels of the frame decoder: received bytes and results
// ----------------------------------------------------------------------------
interface lpfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_kind;
   logic [7:0]  payload_byte;
   logic [1:0]  frame_status;
   logic [13:0] frame_length;

   modport source (output valid, output out_kind, output payload_byte,
                   output frame_status, output frame_length, input ready);
   modport sink (input valid, input out_kind, input payload_byte,
                 input frame_status, input frame_length, output ready);
endinterface

FILE: sv/length_prefixed_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder_unit
// hunts for the start byte, reads a 7-bit-group length, passes payload bytes
// through and closes each frame with a status item (xor checksum)
// ----------------------------------------------------------------------------
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   rx_byte
//   rsp_ch   out  valid/ready   out_kind, payload_byte, frame_status, frame_length
//   csr_*    in   write enable  start_byte
//
// one byte per cycle while req ready is high; the parser state updates in the
// cycle of acceptance and a result appears in the output register on the next cycle
// req ready is high while the output register is empty or being drained
// synchronous reset: start byte 0x7e, parser hunting, no result pending
// ----------------------------------------------------------------------------
module length_prefixed_frame_decoder_unit import lpfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   lpfd_req_if.sink          req_ch,
   lpfd_rsp_if.source        rsp_ch,
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data
);

   logic [BYTE_W-1:0] start_byte_ff;
   result_type        out_ff, out_in;
   result_type        core_result;
   logic              accept;

   assign req_ch.ready = !out_ff.valid || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   lpfd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_ch.rx_byte),
      .start_byte (start_byte_ff),
      .result     (core_result)
   );

   always_comb begin
      out_in = out_ff;
      if (core_result.valid) begin
         out_in = core_result;
      end else if (rsp_ch.ready) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         out_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            start_byte_ff <= csr_wr_data;
         end
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid        = out_ff.valid;
   assign rsp_ch.out_kind     = out_ff.kind;
   assign rsp_ch.payload_byte = out_ff.data;
   assign rsp_ch.frame_status = out_ff.status;
   assign rsp_ch.frame_length = out_ff.length;

endmodule

FILE: sv/lpfd_core.sv
// ----------------------------------------------------------------------------
// lpfd_core
// frame parser state machine: one received byte per accepted item
// ----------------------------------------------------------------------------
module lpfd_core import lpfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic [BYTE_W-1:0] start_byte,
   output result_type        result
);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN,
      PH_DATA,
      PH_CHECK,
      PH_FILLER
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [LEN_W-1:0]       frame_len_ff, frame_len_in;
   logic [LEN_W-1:0]       byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]      running_xor_ff, running_xor_in;
   logic [LEN_CNT_W-1:0]   len_seen_ff, len_seen_in;

   logic [LEN_W-1:0]       len_grown;
   logic                   len_overflow;
   logic [LEN_W-1:0]       count_next;

   assign len_grown    = {frame_len_ff[LEN_W-LEN_GROUP_W-1:0], rx_byte[LEN_GROUP_W-1:0]};
   assign len_overflow = (frame_len_ff[LEN_W-1:LEN_W-LEN_GROUP_W] != '0);
   assign count_next   = byte_count_ff + LEN_W'(1);

   always_comb begin
      phase_in       = phase_ff;
      frame_len_in   = frame_len_ff;
      byte_count_in  = byte_count_ff;
      running_xor_in = running_xor_ff;
      len_seen_in    = len_seen_ff;
      result         = '0;

      case (phase_ff)
         PH_LEN: begin
            if (len_seen_ff >= LEN_CNT_W'(MAX_LEN_BYTES) || len_overflow) begin
               phase_in      = PH_HUNT;
               result.valid  = 1'b1;
               result.kind   = KIND_END;
               result.status = STATUS_LEN_ERR;
               result.length = frame_len_ff;
            end else begin
               running_xor_in = running_xor_ff ^ rx_byte;
               frame_len_in   = len_grown;
               if (rx_byte[BYTE_W-1]) begin
                  len_seen_in = len_seen_ff + LEN_CNT_W'(1);
               end else begin
                  byte_count_in = '0;
                  phase_in      = (len_grown == '0) ? PH_CHECK : PH_DATA;
               end
            end
         end
         PH_DATA: begin
            running_xor_in = running_xor_ff ^ rx_byte;
            byte_count_in  = count_next;
            if (count_next >= frame_len_ff) begin
               phase_in = PH_CHECK;
            end
            result.valid = 1'b1;
            result.kind  = KIND_DATA;
            result.data  = rx_byte;
         end
         PH_CHECK: begin
            running_xor_in = running_xor_ff ^ rx_byte;
            phase_in       = PH_FILLER;
         end
         PH_FILLER: begin
            phase_in      = PH_HUNT;
            result.valid  = 1'b1;
            result.kind   = KIND_END;
            result.status = (running_xor_ff == '0) ? STATUS_GOOD : STATUS_BAD_CSUM;
            result.length = frame_len_ff;
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == start_byte) begin
               running_xor_in = rx_byte;
               frame_len_in   = '0;
               byte_count_in  = '0;
               len_seen_in    = '0;
               phase_in       = PH_LEN;
            end
         end
      endcase

      if (!accept) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         frame_len_ff   <= '0;
         byte_count_ff  <= '0;
         running_xor_ff <= '0;
         len_seen_ff    <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         frame_len_ff   <= frame_len_in;
         byte_count_ff  <= byte_count_in;
         running_xor_ff <= running_xor_in;
         len_seen_ff    <= len_seen_in;
      end
   end

endmodule

FILE: sv/lpfd_checker.sv
// ----------------------------------------------------------------------------
// lpfd_checker
// port-level checks of the frame decoder, bound to the top level
// ----------------------------------------------------------------------------
module lpfd_checker import lpfd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              out_kind,
   input logic [BYTE_W-1:0] payload_byte,
   input logic [1:0]        frame_status,
   input logic [13:0]       frame_length
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_kind)
         && $stable(payload_byte) && $stable(frame_status) && $stable(frame_length))
      else $error("result changed while stalled");

   // data items carry no status and no length
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_kind == KIND_DATA |-> frame_status == STATUS_GOOD
         && frame_length == '0)
      else $error("data item with status or length");

   // frame-end items carry no byte and a known status
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_kind == KIND_END |-> payload_byte == '0
         && (frame_status == STATUS_GOOD || frame_status == STATUS_BAD_CSUM
             || frame_status == STATUS_LEN_ERR))
      else $error("bad frame-end item");

   // input stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input blocked without a stalled result");

   // nothing pending after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind length_prefixed_frame_decoder_unit lpfd_checker u_lpfd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .out_kind     (rsp_ch.out_kind),
   .payload_byte (rsp_ch.payload_byte),
   .frame_status (rsp_ch.frame_status),
   .frame_length (rsp_ch.frame_length)
);

FILE: tb/length_prefixed_frame_decoder_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder_unit_checker
// watches the byte channel, the result channel and the start byte port,
// predicts every result item from the accepted bytes and compares each
// accepted result with the oldest owed one, field by field
// ----------------------------------------------------------------------------
module length_prefixed_frame_decoder_unit_checker import lpfd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_out_kind,
   input  logic [BYTE_W-1:0]   rsp_payload_byte,
   input  logic [STATUS_W-1:0] rsp_frame_status,
   input  logic [LEN_W-1:0]    rsp_frame_length,
   input  logic                csr_wr_en,
   input  logic [BYTE_W-1:0]   csr_wr_data,
   output int unsigned         results_owed,
   output int unsigned         mismatch_count
);

   localparam int unsigned LEN_LIMIT = (1 << LEN_W) - 1;

   typedef enum logic [2:0] {
      SCAN_START,
      READ_LENGTH,
      PASS_PAYLOAD,
      TAKE_CHECKSUM,
      TAKE_FILLER
   } parse_state_type;

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    length;
   } frame_item_type;

   frame_item_type       owed_items[$];
   frame_item_type       oldest;
   logic [BYTE_W-1:0]    start_code;
   parse_state_type      parse_state;
   logic [LEN_W-1:0]     length_acc;
   logic [LEN_W-1:0]     payload_seen;
   logic [BYTE_W-1:0]    xor_acc;
   logic [LEN_CNT_W-1:0] groups_seen;

   initial begin
      results_owed   = 0;
      mismatch_count = 0;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic frame_item_type end_item(input logic [STATUS_W-1:0] status,
                                               input logic [LEN_W-1:0] length);
      frame_item_type it;
      it.kind   = KIND_END;
      it.data   = '0;
      it.status = status;
      it.length = length;
      return it;
   endfunction

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      logic [LEN_W+LEN_GROUP_W-1:0] grown;
      frame_item_type               it;
      grown = {length_acc, b[LEN_GROUP_W-1:0]};
      case (parse_state)
         READ_LENGTH: begin
            // one length byte too many, or a length beyond the field: abort
            if (groups_seen >= LEN_CNT_W'(MAX_LEN_BYTES) || 32'(grown) > LEN_LIMIT) begin
               parse_state = SCAN_START;
               owed_items.push_back(end_item(STATUS_LEN_ERR, length_acc));
            end else begin
               xor_acc    = xor_acc ^ b;
               length_acc = grown[LEN_W-1:0];
               if (b[BYTE_W-1]) begin
                  groups_seen = groups_seen + LEN_CNT_W'(1);
               end else begin
                  payload_seen = '0;
                  if (length_acc == '0) begin
                     parse_state = TAKE_CHECKSUM;
                  end else begin
                     parse_state = PASS_PAYLOAD;
                  end
               end
            end
         end
         PASS_PAYLOAD: begin
            xor_acc      = xor_acc ^ b;
            payload_seen = payload_seen + LEN_W'(1);
            if (payload_seen >= length_acc) begin
               parse_state = TAKE_CHECKSUM;
            end
            it.kind   = KIND_DATA;
            it.data   = b;
            it.status = STATUS_GOOD;
            it.length = '0;
            owed_items.push_back(it);
         end
         TAKE_CHECKSUM: begin
            xor_acc     = xor_acc ^ b;
            parse_state = TAKE_FILLER;
         end
         TAKE_FILLER: begin
            parse_state = SCAN_START;
            if (xor_acc == '0) begin
               owed_items.push_back(end_item(STATUS_GOOD, length_acc));
            end else begin
               owed_items.push_back(end_item(STATUS_BAD_CSUM, length_acc));
            end
         end
         default: begin
            parse_state = SCAN_START;
            if (b == start_code) begin
               xor_acc      = b;
               length_acc   = '0;
               payload_seen = '0;
               groups_seen  = '0;
               parse_state  = READ_LENGTH;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_code   = START_BYTE_RESET;
         parse_state  = SCAN_START;
         length_acc   = '0;
         payload_seen = '0;
         xor_acc      = '0;
         groups_seen  = '0;
         owed_items.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_items.size() == 0) begin
               report_mismatch("result item with none owed",
                               32'({rsp_out_kind, rsp_payload_byte, rsp_frame_status,
                                    rsp_frame_length}), 0);
            end else begin
               oldest = owed_items.pop_front();
               if (rsp_out_kind !== oldest.kind) begin
                  report_mismatch("out_kind", 32'(rsp_out_kind), 32'(oldest.kind));
               end
               if (rsp_payload_byte !== oldest.data) begin
                  report_mismatch("payload_byte", 32'(rsp_payload_byte),
                                  32'(oldest.data));
               end
               if (rsp_frame_status !== oldest.status) begin
                  report_mismatch("frame_status", 32'(rsp_frame_status),
                                  32'(oldest.status));
               end
               if (rsp_frame_length !== oldest.length) begin
                  report_mismatch("frame_length", 32'(rsp_frame_length),
                                  32'(oldest.length));
               end
            end
         end
         if (req_valid && req_ready) begin
            decode_byte(req_rx_byte);
         end
         if (csr_wr_en) begin
            start_code = csr_wr_data;
         end
      end
      results_owed <= owed_items.size();
   end

endmodule

FILE: tb/length_prefixed_frame_decoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder_unit_test
// drives framed byte streams into the decoder under several start bytes,
// with random gaps and stalls on both channels, and gives the verdict from
// the mismatch count of the checker that runs beside the block
// ----------------------------------------------------------------------------
module length_prefixed_frame_decoder_unit_test;
   import lpfd_pkg::*;

   localparam int PHASE_ITEMS    = 400;
   localparam int SETTLE_CYCLES  = 2;
   localparam int TAIL_CYCLES    = 4;
   localparam int HOLD_CYCLES    = 48;
   localparam int WATCHDOG_LIMIT = 2000;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [BYTE_W-1:0] csr_wr_data;
   int unsigned       results_owed;
   int unsigned       mismatch_count;
   int unsigned       bytes_sent;
   int unsigned       hold_requests;
   bit                idle_on;
   logic [BYTE_W-1:0] payload_q[$];

   lpfd_req_if req_ch();
   lpfd_rsp_if rsp_ch();

   length_prefixed_frame_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   length_prefixed_frame_decoder_unit_checker frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_rx_byte      (req_ch.rx_byte),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_out_kind     (rsp_ch.out_kind),
      .rsp_payload_byte (rsp_ch.payload_byte),
      .rsp_frame_status (rsp_ch.frame_status),
      .rsp_frame_length (rsp_ch.frame_length),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .results_owed     (results_owed),
      .mismatch_count   (mismatch_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // result side: random stalls, plus a long hold-off on request
   initial begin : result_sink
      int unsigned holds_done;
      holds_done = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("FAIL length_prefixed_frame_decoder_unit");
      $finish;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_start(input logic [BYTE_W-1:0] sb);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sb;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic fill_payload(input int n);
      payload_q.delete();
      repeat (n) payload_q.push_back(8'($urandom_range(0, 255)));
   endtask

   // start, length, payload_q, checksum (xor-ed with flip), filler
   task automatic send_frame(input logic [BYTE_W-1:0] sb, input bit long_form,
                             input logic [BYTE_W-1:0] flip);
      logic [BYTE_W-1:0] csum;
      logic [LEN_W-1:0]  len;
      len  = LEN_W'(payload_q.size());
      csum = sb;
      send_byte(sb);
      if (long_form || len[LEN_W-1:LEN_GROUP_W] != '0) begin
         send_byte({1'b1, len[LEN_W-1:LEN_GROUP_W]});
         csum = csum ^ {1'b1, len[LEN_W-1:LEN_GROUP_W]};
      end
      send_byte({1'b0, len[LEN_GROUP_W-1:0]});
      csum = csum ^ {1'b0, len[LEN_GROUP_W-1:0]};
      foreach (payload_q[i]) begin
         send_byte(payload_q[i]);
         csum = csum ^ payload_q[i];
      end
      send_byte(csum ^ flip);
      send_byte(8'($urandom_range(0, 255)));
   endtask

   // two length bytes that both ask for more, then the one that aborts
   task automatic send_overlong(input logic [BYTE_W-1:0] sb,
                                input logic [LEN_GROUP_W-1:0] g1,
                                input logic [LEN_GROUP_W-1:0] g2,
                                input logic [BYTE_W-1:0] tail);
      send_byte(sb);
      send_byte({1'b1, g1});
      send_byte({1'b1, g2});
      send_byte(tail);
   endtask

   function automatic int random_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 0;
      if (r < 70) return $urandom_range(1, 15);
      if (r < 95) return $urandom_range(16, 200);
      return $urandom_range(201, 600);
   endfunction

   function automatic logic [BYTE_W-1:0] noise_byte(input logic [BYTE_W-1:0] sb);
      logic [BYTE_W-1:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == sb) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   task automatic run_phase(input logic [BYTE_W-1:0] sb, input bit pressure);
      int unsigned base;
      int          pick;
      int          len;
      bit          held;
      bit          drained;
      held    = 1'b0;
      drained = 1'b0;
      set_start(sb);
      base = bytes_sent;
      while (bytes_sent - base < PHASE_ITEMS) begin
         if (pressure && !held && bytes_sent - base > PHASE_ITEMS / 3) begin
            hold_requests <= hold_requests + 1;
            held = 1'b1;
         end
         if (pressure && !drained && bytes_sent - base > 2 * PHASE_ITEMS / 3) begin
            wait_idle();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            fill_payload(random_length());
            send_frame(sb, $urandom_range(0, 4) == 0, '0);
         end else if (pick < 82) begin
            fill_payload(random_length());
            send_frame(sb, $urandom_range(0, 4) == 0, 8'($urandom_range(1, 255)));
         end else if (pick < 90) begin
            send_overlong(sb, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                          8'($urandom_range(0, 255)));
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 4)) send_byte(noise_byte(sb));
         end else begin
            // cut frame: the next frame's bytes are taken as payload
            len = $urandom_range(2, 12);
            send_byte(sb);
            send_byte(8'(len));
            repeat ($urandom_range(1, len - 1)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= START_BYTE_RESET;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      idle_on        <= 1'b1;
      hold_requests  <= 0;
      bytes_sent     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed frames under the reset start byte
      payload_q = '{8'h00};
      send_frame(START_BYTE_RESET, 1'b0, '0);
      payload_q = '{8'hFF, START_BYTE_RESET, 8'h80};
      send_frame(START_BYTE_RESET, 1'b1, '0);
      payload_q.delete();
      send_frame(START_BYTE_RESET, 1'b0, '0);
      send_frame(START_BYTE_RESET, 1'b0, 8'h01);
      fill_payload(2);
      send_frame(START_BYTE_RESET, 1'b0, 8'h80);
      fill_payload(130);
      send_frame(START_BYTE_RESET, 1'b0, '0);
      send_overlong(START_BYTE_RESET, 7'h7F, 7'h7F, 8'h00);
      send_overlong(START_BYTE_RESET, 7'h00, 7'h00, 8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h7D);

      // start byte rewritten inside a frame
      send_byte(START_BYTE_RESET);
      send_byte(8'h02);
      set_start(8'h5A);
      send_byte(8'h5A);
      send_byte(8'h11);
      send_byte(START_BYTE_RESET ^ 8'h02 ^ 8'h5A ^ 8'h11);
      send_byte(8'h00);
      fill_payload(4);
      send_frame(8'h5A, 1'b0, '0);

      // random frames under several start bytes
      run_phase(8'h00, 1'b1);
      run_phase(8'hFF, 1'b1);
      run_phase(8'($urandom_range(0, 255)), 1'b1);
      run_phase(8'($urandom_range(0, 255)), 1'b0);
      wait_idle();
      idle_on <= 1'b0;
      run_phase(START_BYTE_RESET, 1'b0);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS length_prefixed_frame_decoder_unit");
      end else begin
         $display("FAIL length_prefixed_frame_decoder_unit");
      end
      $finish;
   end

endmodule

FILE: length_prefixed_frame_decoder_unit.f
sv/lpfd_pkg.sv
sv/lpfd_if.sv
sv/lpfd_core.sv
sv/length_prefixed_frame_decoder_unit.sv
sv/lpfd_checker.sv
tb/length_prefixed_frame_decoder_unit_checker.sv
tb/length_prefixed_frame_decoder_unit_test.sv
